// ===== rtl/rfc_pkg.sv =====
// Shared types, constants and helpers for the relay failover controller.
`default_nettype none

package rfc_pkg;

	// Relay slots that the storage supports; the live count never exceeds four.
	localparam int MAX_RELAY_SLOTS = 4;
	localparam int RELAY_LIMIT     = (MAX_RELAY_SLOTS < 4) ? MAX_RELAY_SLOTS : 4;

	// Event queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Input command codes.
	localparam logic [1:0] CMD_START     = 2'd0;
	localparam logic [1:0] CMD_TICK      = 2'd1;
	localparam logic [1:0] CMD_TICK_DATA = 2'd2;
	localparam logic [1:0] CMD_RX        = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_KEEPALIVE = 2'd0;
	localparam logic [1:0] KIND_REGISTER  = 2'd1;
	localparam logic [1:0] KIND_DATA      = 2'd2;

	// Switch event codes.
	localparam logic [1:0] SW_NONE     = 2'd0;
	localparam logic [1:0] SW_FAILOVER = 2'd1;
	localparam logic [1:0] SW_FAILBACK = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_RELAY_COUNT   = 3'd0;
	localparam logic [2:0] REG_KEEPALIVE     = 3'd1;
	localparam logic [2:0] REG_RX_IDLE       = 3'd2;
	localparam logic [2:0] REG_PROBE_TIMEOUT = 3'd3;
	localparam logic [2:0] REG_FAILBACK      = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [2:0]  RST_RELAY_COUNT   = 3'd1;
	localparam logic [31:0] RST_KEEPALIVE     = 32'd25000;
	localparam logic [31:0] RST_RX_IDLE       = 32'd5000;
	localparam logic [31:0] RST_PROBE_TIMEOUT = 32'd3000;
	localparam logic [31:0] RST_FAILBACK      = 32'd10000;

	typedef enum logic [1:0] {
		OP_START,
		OP_TICK,
		OP_TICK_DATA,
		OP_RX
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] now;
		logic [1:0]  idx;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] target;
		logic [1:0] sw;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [2:0]  num_relays;
		logic [31:0] keepalive_ms;
		logic [31:0] rx_idle_ms;
		logic [31:0] probe_timeout_ms;
		logic [31:0] failback_ms;
	} cfg_t;

	// Relay count clamped into 1..RELAY_LIMIT.
	function automatic logic [2:0] live_count(input logic [2:0] cnt);
		logic [2:0] c;
		c = cnt;
		if (c == 3'd0)
			c = 3'd1;
		if (c > 3'(RELAY_LIMIT))
			c = 3'(RELAY_LIMIT);
		return c;
	endfunction

	// (cur + 1) mod cnt by repeated subtraction; cnt is at least one.
	function automatic logic [1:0] next_relay(input logic [1:0] cur, input logic [2:0] cnt);
		logic [2:0] v;
		v = {1'b0, cur} + 3'd1;
		for (int k = 0; k < RELAY_LIMIT; k++) begin
			if (v >= cnt)
				v = v - cnt;
		end
		return v[1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rfc_front.sv =====
// Front stage: takes event beats, decodes the command, feeds the event queue.
`default_nettype none

module rfc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [1:0]     cmd,
	input  wire logic [31:0]    now_ms,
	input  wire logic [1:0]     relay_idx,
	input  wire logic           q_full,
	output logic                q_push,
	output rfc_pkg::item_t      q_item
);
	import rfc_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	op_t   op_dec;

	always_comb begin
		unique case (cmd)
			CMD_START:     op_dec = OP_START;
			CMD_TICK:      op_dec = OP_TICK;
			CMD_TICK_DATA: op_dec = OP_TICK_DATA;
			CMD_RX:        op_dec = OP_RX;
			default:       op_dec = OP_TICK;
		endcase
	end

	assign in_stall = valid_s1 && q_full;
	assign q_push   = valid_s1 && !q_full;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.op  <= op_dec;
			item_s1.now <= now_ms;
			item_s1.idx <= relay_idx;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rfc_queue.sv =====
// Short event queue between the front and the back.
`default_nettype none

module rfc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  rfc_pkg::item_t      push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                nempty,
	output rfc_pkg::item_t      head
);
	import rfc_pkg::*;

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign nempty = (cnt_q != '0);
	assign head   = slot_q[rd_q];

	function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		if (p == QPTR_W'(QUEUE_DEPTH - 1))
			r = '0;
		else
			r = p + 1'b1;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= bump(wr_q);
			if (pop)
				rd_q <= bump(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_item;
	end

endmodule

`default_nettype wire

// ===== rtl/rfc_back.sv =====
// Back end: relay state, failover sequencer and result register.
`default_nettype none

module rfc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  rfc_pkg::cfg_t       cfg,
	input  wire logic           q_nempty,
	input  rfc_pkg::item_t      q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output rfc_pkg::res_t       out_res
);
	import rfc_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_START  = 10'b0000000010,
		ST_RX     = 10'b0000000100,
		ST_KA     = 10'b0000001000,
		ST_FB     = 10'b0000010000,
		ST_FBLOOP = 10'b0000100000,
		ST_RXCHK  = 10'b0001000000,
		ST_PTO    = 10'b0010000000,
		ST_DATA   = 10'b0100000000,
		ST_FLUSH  = 10'b1000000000
	} state_t;

	state_t      state_q, state_d;
	item_t       item_q, item_d;
	logic [1:0]  cur_q, cur_d;
	logic [31:0] last_rx_q, last_rx_d;
	logic [31:0] last_send_q, last_send_d;
	logic [31:0] probe_time_q, probe_time_d;
	logic        probe_q, probe_d;
	logic [31:0] last_fb_q, last_fb_d;
	logic [1:0]  i_q, i_d;

	// One-result hold so that the final result of an event can carry last.
	logic        pend_v_q, pend_v_d;
	res_t        pend_q;

	logic        out_valid_q;
	res_t        out_res_q;
	logic        out_free;
	logic        out_load;

	logic [2:0]  cnt;
	logic [31:0] tbase, tlimit, tdiff;
	logic        elapsed;
	logic        emit_v, emit_ok, flush;
	logic [1:0]  emit_kind, emit_tgt, emit_sw;
	logic [1:0]  nxt_relay;
	state_t      after_probe;

	assign cnt      = live_count(cfg.num_relays);
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// One shared subtract and compare; the state picks the stamp and limit.
	always_comb begin
		unique case (state_q)
			ST_KA: begin
				tbase  = last_send_q;
				tlimit = cfg.keepalive_ms;
			end
			ST_FB: begin
				tbase  = last_fb_q;
				tlimit = cfg.failback_ms;
			end
			ST_PTO: begin
				tbase  = probe_time_q;
				tlimit = cfg.probe_timeout_ms;
			end
			default: begin
				tbase  = last_rx_q;
				tlimit = cfg.rx_idle_ms;
			end
		endcase
		tdiff   = item_q.now - tbase;
		elapsed = (tdiff >= tlimit);
	end

	assign nxt_relay   = next_relay(cur_q, cnt);
	assign after_probe = (item_q.op == OP_TICK_DATA) ? ST_DATA : ST_FLUSH;

	always_comb begin
		state_d      = state_q;
		item_d       = item_q;
		cur_d        = cur_q;
		last_rx_d    = last_rx_q;
		probe_time_d = probe_time_q;
		probe_d      = probe_q;
		last_fb_d    = last_fb_q;
		i_d          = i_q;
		emit_v       = 1'b0;
		emit_kind    = KIND_KEEPALIVE;
		emit_tgt     = cur_q;
		emit_sw      = SW_NONE;
		flush        = 1'b0;
		q_pop        = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (q_nempty) begin
					q_pop  = 1'b1;
					item_d = q_head;
					case (q_head.op)
						OP_START: state_d = ST_START;
						OP_RX:    state_d = ST_RX;
						default:  state_d = ST_KA;
					endcase
				end
			end
			ST_START: begin
				if (out_free) begin
					cur_d     = 2'd0;
					last_rx_d = item_q.now;
					emit_v    = 1'b1;
					emit_kind = KIND_REGISTER;
					emit_tgt  = 2'd0;
					state_d   = ST_FLUSH;
				end
			end
			ST_RX: begin
				if (out_free) begin
					if ({1'b0, item_q.idx} < cnt) begin
						if (item_q.idx == cur_q) begin
							last_rx_d = item_q.now;
							probe_d   = 1'b0;
						end else if (item_q.idx < cur_q) begin
							cur_d     = item_q.idx;
							last_rx_d = item_q.now;
							probe_d   = 1'b0;
							emit_v    = 1'b1;
							emit_kind = KIND_REGISTER;
							emit_tgt  = item_q.idx;
							emit_sw   = SW_FAILBACK;
						end
					end
					state_d = ST_FLUSH;
				end
			end
			ST_KA: begin
				if (out_free) begin
					emit_v  = elapsed;
					state_d = ST_FB;
				end
			end
			ST_FB: begin
				if (out_free) begin
					if (cur_q != 2'd0 && elapsed) begin
						last_fb_d = item_q.now;
						i_d       = 2'd0;
						state_d   = ST_FBLOOP;
					end else begin
						state_d = ST_RXCHK;
					end
				end
			end
			ST_FBLOOP: begin
				if (out_free) begin
					emit_v   = 1'b1;
					emit_tgt = i_q;
					i_d      = i_q + 2'd1;
					if ((i_q + 2'd1) == cur_q)
						state_d = ST_RXCHK;
				end
			end
			ST_RXCHK: begin
				if (out_free) begin
					if (elapsed) begin
						if (!probe_q) begin
							emit_v       = 1'b1;
							probe_d      = 1'b1;
							probe_time_d = item_q.now;
							state_d      = after_probe;
						end else begin
							state_d = ST_PTO;
						end
					end else begin
						state_d = after_probe;
					end
				end
			end
			ST_PTO: begin
				if (out_free) begin
					if (elapsed) begin
						cur_d     = nxt_relay;
						probe_d   = 1'b0;
						last_rx_d = item_q.now;
						emit_v    = 1'b1;
						emit_kind = KIND_REGISTER;
						emit_tgt  = nxt_relay;
						emit_sw   = (nxt_relay != cur_q) ? SW_FAILOVER : SW_NONE;
					end
					state_d = after_probe;
				end
			end
			ST_DATA: begin
				if (out_free) begin
					emit_v    = 1'b1;
					emit_kind = KIND_DATA;
					state_d   = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					flush   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Orders to a relay beyond the live count are dropped.
	assign emit_ok  = emit_v && ({1'b0, emit_tgt} < cnt);
	assign out_load = pend_v_q && (emit_ok || flush);

	always_comb begin
		last_send_d = last_send_q;
		if (emit_ok && emit_tgt == cur_d)
			last_send_d = item_q.now;
		pend_v_d = pend_v_q;
		if (emit_ok)
			pend_v_d = 1'b1;
		else if (flush)
			pend_v_d = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q        <= '0;
			last_rx_q    <= '0;
			last_send_q  <= '0;
			probe_time_q <= '0;
			probe_q      <= 1'b0;
			last_fb_q    <= '0;
			pend_v_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			cur_q        <= cur_d;
			last_rx_q    <= last_rx_d;
			last_send_q  <= last_send_d;
			probe_time_q <= probe_time_d;
			probe_q      <= probe_d;
			last_fb_q    <= last_fb_d;
			pend_v_q     <= pend_v_d;
			if (out_free)
				out_valid_q <= out_load;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		i_q    <= i_d;
		if (emit_ok) begin
			pend_q.kind   <= emit_kind;
			pend_q.target <= emit_tgt;
			pend_q.sw     <= emit_sw;
			pend_q.last   <= 1'b0;
		end
		if (out_load) begin
			out_res_q.kind   <= pend_q.kind;
			out_res_q.target <= pend_q.target;
			out_res_q.sw     <= pend_q.sw;
			out_res_q.last   <= flush;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/relay_failover_controller.sv =====
// Top level of the relay failover controller: ports, configuration registers, wiring.
`default_nettype none

// Relay failover controller. Each input beat is one event (start, tick, tick
// followed by a data send, or packet received) stamped with a wrapping ms time;
// the block answers with zero to six send orders, one per output beat, the final
// one flagged by last. A front stage decodes events into a two-entry queue, so
// events can be taken while the back end is still busy; the back end works one
// event at a time through a sequencer that shares a single 32-bit subtract and
// compare across the time checks. Start and packet-received events go through
// their own state and a flush state; a tick goes through keepalive, failback
// check, one sweep step per higher-priority relay, receive check, probe timeout
// if pending, data send if asked, flush. A stalled output holds the sequencer.
// Configuration is taken at any time (cfg_ready is tied high) but is meant to
// change only while the block is idle. A relay count outside 1..4 is clamped.
module relay_failover_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// event channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [31:0] now_ms,
	input  wire logic [1:0]  relay_idx,
	// send order channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [1:0]       target,
	output logic [1:0]       switch_event,
	output logic             last,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import rfc_pkg::*;

	cfg_t  cfg_q;
	item_t push_item;
	item_t head;
	res_t  res;
	logic  q_full, q_push, q_pop, q_nempty;

	assign cfg_ready = 1'b1;

	// Register file; writes beyond the last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_relays       <= RST_RELAY_COUNT;
			cfg_q.keepalive_ms     <= RST_KEEPALIVE;
			cfg_q.rx_idle_ms       <= RST_RX_IDLE;
			cfg_q.probe_timeout_ms <= RST_PROBE_TIMEOUT;
			cfg_q.failback_ms      <= RST_FAILBACK;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RELAY_COUNT:   cfg_q.num_relays       <= cfg_data[2:0];
				REG_KEEPALIVE:     cfg_q.keepalive_ms     <= cfg_data;
				REG_RX_IDLE:       cfg_q.rx_idle_ms       <= cfg_data;
				REG_PROBE_TIMEOUT: cfg_q.probe_timeout_ms <= cfg_data;
				REG_FAILBACK:      cfg_q.failback_ms      <= cfg_data;
				default: ;
			endcase
		end
	end

	rfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.now_ms    (now_ms),
		.relay_idx (relay_idx),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	rfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.nempty    (q_nempty),
		.head      (head)
	);

	rfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_nempty  (q_nempty),
		.q_head    (head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res)
	);

	// Result beat fields.
	assign kind         = res.kind;
	assign target       = res.target;
	assign switch_event = res.sw;
	assign last         = res.last;

endmodule

`default_nettype wire

// ===== tb/relay_failover_controller_test.sv =====
// Self-checking testbench for the relay failover controller: directed and random event streams.
`timescale 1ns / 100ps

module relay_failover_controller_test;
	import rfc_pkg::*;

	// Cycles left after the last expected order before the block counts as idle.
	// A tick with data is the longest event for the back end, and the queue holds two events.
	localparam int SETTLE_CYCLES = 48;
	// Cycles with no beat on any channel before the run is called hung.
	localparam int HANG_LIMIT    = 4000;
	localparam int MAX_ORDERS    = 6;

	// ---------------------------------------------------------------- DUT wiring
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd       = CMD_START;
	logic [31:0] now_ms    = '0;
	logic [1:0]  relay_idx = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [1:0]  target;
	logic [1:0]  switch_event;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_RELAY_COUNT;
	logic [31:0] cfg_data  = '0;

	relay_failover_controller i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.now_ms       (now_ms),
		.relay_idx    (relay_idx),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.target       (target),
		.switch_event (switch_event),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------- shared state
	// Idling knobs, in percent of cycles.
	int send_idle_pct = 0;
	int stall_pct     = 0;

	int mismatches  = 0;
	int idle_cycles = 0;

	// Running event time; every sent beat updates it.
	logic [31:0] t_ms = '0;

	// Orders still owed by the block, oldest first.
	res_t expected_orders[$];
	// Orders worked out for the event in hand.
	res_t step_orders[$];

	// Policy mirror: configuration, starting from the reset values.
	logic [2:0]  cnt_reg       = RST_RELAY_COUNT;
	logic [31:0] keepalive_lim = RST_KEEPALIVE;
	logic [31:0] rx_idle_lim   = RST_RX_IDLE;
	logic [31:0] probe_lim     = RST_PROBE_TIMEOUT;
	logic [31:0] failback_lim  = RST_FAILBACK;

	// Policy mirror: relay state, all zero after reset.
	logic [1:0]  cur_idx        = '0;
	logic [31:0] rx_stamp       = '0;
	logic [31:0] send_stamp     = '0;
	logic [31:0] probe_stamp    = '0;
	logic        probe_armed    = 1'b0;
	logic [31:0] failback_stamp = '0;
	logic [31:0] ev_now         = '0;

	// ---------------------------------------------------------------- policy mirror
	// Relay count as the block uses it: zero acts as one, anything high as the limit.
	function automatic int live_relays();
		int c;
		c = int'(cnt_reg);
		if (c < 1)
			c = 1;
		if (c > RELAY_LIMIT)
			c = RELAY_LIMIT;
		return c;
	endfunction

	// Orders to a relay beyond the live count vanish and leave send_stamp alone.
	function automatic void queue_order(logic [1:0] k, logic [1:0] tgt, logic [1:0] sw);
		res_t o;
		if (int'(tgt) >= live_relays() || step_orders.size() >= MAX_ORDERS)
			return;
		o.kind   = k;
		o.target = tgt;
		o.sw     = sw;
		o.last   = 1'b0;
		step_orders.push_back(o);
		if (tgt == cur_idx)
			send_stamp = ev_now;
	endfunction

	// Keepalive, failback sweep, then probe / failover; all differences wrap at 2^32.
	function automatic void tick_policy(logic [31:0] t);
		logic [1:0] nxt;
		logic [1:0] sw;
		if (32'(t - send_stamp) >= keepalive_lim)
			queue_order(KIND_KEEPALIVE, cur_idx, SW_NONE);
		if (cur_idx != 2'd0 && 32'(t - failback_stamp) >= failback_lim) begin
			failback_stamp = t;
			for (int i = 0; i < int'(cur_idx); i++)
				queue_order(KIND_KEEPALIVE, 2'(i), SW_NONE);
		end
		if (32'(t - rx_stamp) >= rx_idle_lim) begin
			if (!probe_armed) begin
				queue_order(KIND_KEEPALIVE, cur_idx, SW_NONE);
				probe_armed = 1'b1;
				probe_stamp = t;
			end else if (32'(t - probe_stamp) >= probe_lim) begin
				// with a single live relay the move lands where it started: no switch
				nxt = 2'((int'(cur_idx) + 1) % live_relays());
				sw  = SW_NONE;
				if (nxt != cur_idx) begin
					cur_idx = nxt;
					sw      = SW_FAILOVER;
				end
				probe_armed = 1'b0;
				rx_stamp    = t;
				queue_order(KIND_REGISTER, cur_idx, sw);
			end
		end
	endfunction

	// Works out every order one accepted event owes and files them.
	function automatic void predict_orders(op_t op, logic [31:0] t, logic [1:0] idx);
		res_t o;
		ev_now = t;
		step_orders.delete();
		case (op)
		OP_START: begin
			cur_idx  = 2'd0;
			rx_stamp = t;
			queue_order(KIND_REGISTER, cur_idx, SW_NONE);
		end
		OP_TICK: begin
			tick_policy(t);
		end
		OP_TICK_DATA: begin
			tick_policy(t);
			queue_order(KIND_DATA, cur_idx, SW_NONE);
		end
		default: begin
			// unknown and lower-priority senders are ignored
			if (int'(idx) < live_relays()) begin
				if (idx == cur_idx) begin
					rx_stamp    = t;
					probe_armed = 1'b0;
				end else if (idx < cur_idx) begin
					cur_idx     = idx;
					rx_stamp    = t;
					probe_armed = 1'b0;
					queue_order(KIND_REGISTER, cur_idx, SW_FAILBACK);
				end
			end
		end
		endcase
		foreach (step_orders[i]) begin
			o      = step_orders[i];
			o.last = (i == step_orders.size() - 1);
			expected_orders.push_back(o);
		end
	endfunction

	// ---------------------------------------------------------------- order checker
	always @(posedge clk) begin : check_orders
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_orders.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected order: kind %0d target %0d switch %0d last %0d",
						kind, target, switch_event, last);
			end else begin
				want = expected_orders.pop_front();
				if (kind !== want.kind || target !== want.target ||
						switch_event !== want.sw || last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("order mismatch: exp k%0d t%0d s%0d l%0d, got k%0d t%0d s%0d l%0d",
							want.kind, want.target, want.sw, want.last,
							kind, target, switch_event, last);
				end
			end
		end
	end

	// Receiver back-pressure, redrawn every cycle.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// Hang guard: any beat on any channel resets the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= HANG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- drivers
	task automatic reset_dut();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
	endtask

	// One event beat; valid stays up into the next beat unless a gap is drawn.
	task automatic send_event(op_t op, logic [31:0] t, logic [1:0] idx);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		cmd       <= op;
		now_ms    <= t;
		relay_idx <= idx;
		do
			@(posedge clk);
		while (in_stall);
		t_ms = t;
		predict_orders(op, t, idx);
	endtask

	// Hold off the sender until every owed order has come out.
	task automatic drain_orders();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_orders.size() != 0);
	endtask

	// Writes all five registers once the block has gone quiet.
	task automatic program_config(logic [2:0] cnt, logic [31:0] ka, logic [31:0] idle,
			logic [31:0] pto, logic [31:0] fb);
		logic [31:0] plan [5];
		plan[REG_RELAY_COUNT]   = 32'(cnt);
		plan[REG_KEEPALIVE]     = ka;
		plan[REG_RX_IDLE]       = idle;
		plan[REG_PROBE_TIMEOUT] = pto;
		plan[REG_FAILBACK]      = fb;
		drain_orders();
		// an rx beat owes nothing, so the back end may still be busy here
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		for (int r = REG_RELAY_COUNT; r <= REG_FAILBACK; r++) begin
			cfg_index <= 3'(r);
			cfg_data  <= plan[r];
			do
				@(posedge clk);
			while (!cfg_ready);
			case (3'(r))
			REG_RELAY_COUNT:   cnt_reg       = plan[r][2:0];
			REG_KEEPALIVE:     keepalive_lim = plan[r];
			REG_RX_IDLE:       rx_idle_lim   = plan[r];
			REG_PROBE_TIMEOUT: probe_lim     = plan[r];
			default:           failback_lim  = plan[r];
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------- tests
	// Reset configuration, nothing started yet: probe at the idle boundary,
	// failover with one relay, unknown sender.
	task automatic test_before_start();
		send_event(OP_TICK,      32'd0,    2'd0);
		send_event(OP_RX,        32'd100,  2'd2);
		send_event(OP_TICK,      32'd5000, 2'd0);
		send_event(OP_TICK,      32'd7999, 2'd0);
		send_event(OP_TICK_DATA, 32'd8000, 2'd0);
		send_event(OP_START,     32'd9000, 2'd3);
	endtask

	// Four relays: walk down the chain by probe timeouts, sweep higher relays,
	// one tick with the full six orders, then fail back to relay 1.
	task automatic test_failover_chain();
		program_config(3'd4, 32'd1000, 32'd400, 32'd200, 32'd600);
		send_event(OP_START,     32'd20000, 2'd0);
		send_event(OP_TICK_DATA, 32'd20100, 2'd0);
		send_event(OP_TICK,      32'd20500, 2'd0);
		send_event(OP_TICK,      32'd20700, 2'd0);
		send_event(OP_TICK,      32'd20800, 2'd0);
		send_event(OP_RX,        32'd20850, 2'd2);
		send_event(OP_RX,        32'd20900, 2'd1);
		send_event(OP_TICK,      32'd21300, 2'd0);
		send_event(OP_TICK,      32'd21500, 2'd0);
		send_event(OP_TICK,      32'd22100, 2'd0);
		send_event(OP_TICK,      32'd22300, 2'd0);
		send_event(OP_TICK_DATA, 32'd23400, 2'd0);
		send_event(OP_RX,        32'd23450, 2'd1);
	endtask

	// Carries on from relay 1 with the count cut to one: orders to relay 1 drop,
	// and the next failover wraps to relay 0.
	task automatic test_shrunk_relay_count();
		program_config(3'd1, 32'd1000, 32'd400, 32'd200, 32'd600);
		send_event(OP_TICK_DATA, 32'd23500, 2'd0);
		send_event(OP_TICK,      32'd24000, 2'd0);
		send_event(OP_TICK,      32'd24200, 2'd0);
		send_event(OP_RX,        32'd24300, 2'd3);
	endtask

	// Time wrapping through zero, count above range, limits at both extremes.
	task automatic test_time_wrap();
		program_config(3'd7, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1);
		send_event(OP_START, 32'hFFFF_FFFF, 2'd0);
		send_event(OP_TICK,  32'd0,         2'd3);
	endtask

	// Random events under one configuration and one idling pattern. Time moves
	// in steps near the limits so probes and failovers chain; now and then a
	// large jump. Packets mostly come from the current relay.
	task automatic test_random_traffic(logic [2:0] cnt, logic [31:0] ka, logic [31:0] idle,
			logic [31:0] pto, logic [31:0] fb, int send_pct, int stall_p,
			logic [31:0] step_max, int n);
		op_t        op;
		logic [1:0] idx;
		int         pick;
		logic [31:0] t;
		program_config(cnt, ka, idle, pto, fb);
		send_idle_pct = send_pct;
		stall_pct     = stall_p;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 5)
				op = OP_START;
			else if (pick < 45)
				op = OP_TICK;
			else if (pick < 65)
				op = OP_TICK_DATA;
			else
				op = OP_RX;
			if ($urandom_range(1) == 0)
				idx = cur_idx;
			else
				idx = 2'($urandom_range(3));
			if ($urandom_range(7) == 0)
				t = t_ms + $urandom();
			else
				t = t_ms + $urandom_range(step_max);
			// sender holds back until the block has caught up
			if ($urandom_range(19) == 0)
				drain_orders();
			send_event(op, t, idx);
		end
		send_idle_pct = 0;
		stall_pct     = 0;
	endtask

	// ---------------------------------------------------------------- sequence
	initial begin
		reset_dut();
		test_before_start();
		test_failover_chain();
		test_shrunk_relay_count();
		test_time_wrap();

		test_random_traffic(3'd4, 32'd300, 32'd120, 32'd80, 32'd200, 0, 0, 32'd150, 51);
		test_random_traffic(3'd3, 32'd250, 32'd90, 32'd60, 32'd180, 54, 0, 32'd120, 51);
		test_random_traffic(3'd2, 32'd400, 32'd150, 32'd100, 32'd250, 0, 54, 32'd200, 51);
		test_random_traffic(3'd4, 32'd200, 32'd100, 32'd50, 32'd150, 27, 27, 32'd120, 51);
		// every limit at one: something fires on nearly every tick
		test_random_traffic(3'd0, 32'd1, 32'd1, 32'd1, 32'd1, 0, 0, 32'd3, 51);
		// every limit at the top: only exact full-range gaps fire
		test_random_traffic(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			54, 0, 32'hFFFF_FFFF, 51);
		test_random_traffic(3'($urandom_range(4, 1)), $urandom_range(500, 1),
			$urandom_range(500, 1), $urandom_range(500, 1), $urandom_range(500, 1),
			0, 54, 32'd300, 51);
		test_random_traffic(3'($urandom_range(7)), $urandom_range(500, 1),
			$urandom_range(500, 1), $urandom_range(500, 1), $urandom_range(500, 1),
			27, 27, 32'd300, 51);

		drain_orders();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_orders.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rfc_pkg.sv
rtl/rfc_front.sv
rtl/rfc_queue.sv
rtl/rfc_back.sv
rtl/relay_failover_controller.sv
tb/relay_failover_controller_test.sv
